// ----- rtl/core/sfl_pkg.sv -----
// shared constants, codes and helpers of the segregated free list
`timescale 1ns / 1ps
`default_nettype none

package sfl_pkg;

	// default geometry
	localparam int NUM_CLASSES_DEF = 32;
	localparam int STACK_DEPTH_DEF = 16;

	// log2 offset between a size and its class
	localparam int CLASS_SHIFT = 3;

	// field widths fixed by the interface
	localparam int CMD_W    = 2;
	localparam int ADDR_W   = 32;
	localparam int SIZE_W   = 32;
	localparam int IDX_W    = 5;
	localparam int STATUS_W = 2;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_ADD     = 2'd0,
		CMD_SEARCH  = 2'd1,
		CMD_RELEASE = 2'd2
	} cmd_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ
	} state_t;

	// position of the highest set bit, zero for values 0 and 1
	function automatic logic [5:0] floor_log2(input logic [SIZE_W-1:0] v);
		logic [5:0] r;
		r = '0;
		for (int i = 1; i < SIZE_W; i++) begin
			if (v[i]) begin
				r = 6'(i);
			end
		end
		return r;
	endfunction

	// size class before saturation to the table
	function automatic logic [5:0] size_class(input logic [SIZE_W-1:0] size);
		logic [5:0] lg;
		lg = floor_log2(size);
		return (lg <= 6'(CLASS_SHIFT)) ? 6'd0 : lg - 6'(CLASS_SHIFT);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/segregated_free_list.sv -----
// segregated free list: per-class lifo stacks of free block addresses
//
//   channel | direction | fields                                        | flow control
//   --------+-----------+-----------------------------------------------+----------------------
//   in      | input     | command, block_addr, block_size, class_index  | in_valid / in_stall
//   out     | output    | found, addr_out, status                       | out_valid / out_stall
//
// an add or search passes from transfer in through the capture register, then count
// lookup and stack write, to the result register; a release adds a read step, as the
// popped address comes from the stack memory, a synchronous ram with a registered read.
// one command is in flight at a time; a result waiting in the output register
// holds the next command in its execute step until it is taken.
// reset clears the per-class counts at once; stack contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module segregated_free_list #(
	parameter int NUM_CLASSES = sfl_pkg::NUM_CLASSES_DEF,
	parameter int STACK_DEPTH = sfl_pkg::STACK_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [sfl_pkg::CMD_W-1:0]     command,
	input  wire logic [sfl_pkg::ADDR_W-1:0]    block_addr,
	input  wire logic [sfl_pkg::SIZE_W-1:0]    block_size,
	input  wire logic [sfl_pkg::IDX_W-1:0]     class_index,
	// output channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               found,
	output logic [sfl_pkg::ADDR_W-1:0]         addr_out,
	output logic [sfl_pkg::STATUS_W-1:0]       status
);

	localparam int CW    = $clog2(NUM_CLASSES);
	localparam int NW    = $clog2(STACK_DEPTH + 1);
	localparam int PW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DEPTH = NUM_CLASSES * STACK_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// captured command
	sfl_pkg::state_t               state_q, state_d;
	sfl_pkg::cmd_t                 cmd_q;
	logic [sfl_pkg::ADDR_W-1:0]    addr_q;
	logic [CW-1:0]                 cls_q;
	logic                          cls_ok_q;

	// per-class fill counts and stack storage
	logic [NW-1:0]                 count_q [NUM_CLASSES];
	logic [sfl_pkg::ADDR_W-1:0]    stack_mem [DEPTH];
	logic [sfl_pkg::ADDR_W-1:0]    rd_data_q;

	// result register
	logic                          out_valid_q;
	logic                          found_q;
	logic [sfl_pkg::ADDR_W-1:0]    addr_out_q;
	sfl_pkg::status_t              status_q;

	// control from the sequencer
	logic                          in_xfer;
	logic                          out_free;
	logic [NW-1:0]                 cnt;
	logic [PW-1:0]                 slot;
	logic [AW-1:0]                 mem_addr;
	logic                          mem_we;
	logic                          mem_re;
	logic                          cnt_we;
	logic [NW-1:0]                 cnt_next;
	logic                          res_load;
	logic                          res_found;
	logic [sfl_pkg::ADDR_W-1:0]    res_addr;
	sfl_pkg::status_t              res_status;

	// class of the incoming command
	logic [5:0]                    size_cls;
	logic [CW-1:0]                 in_cls;
	logic                          in_cls_ok;

	assign in_stall = (state_q != sfl_pkg::ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// size to class for add and search, saturated at the top class; release takes class_index, checked against the table
	always_comb begin
		size_cls  = sfl_pkg::size_class(block_size);
		in_cls    = CW'(class_index);
		in_cls_ok = (32'(class_index) < 32'(NUM_CLASSES));
		if (sfl_pkg::cmd_t'(command) != sfl_pkg::CMD_RELEASE) begin
			in_cls_ok = 1'b1;
			if (7'(size_cls) >= 7'(NUM_CLASSES)) begin
				in_cls = CW'(NUM_CLASSES - 1);
			end else begin
				in_cls = CW'(size_cls);
			end
		end
	end

	// capture the command on transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q    <= sfl_pkg::cmd_t'(command);
			addr_q   <= block_addr;
			cls_q    <= in_cls;
			cls_ok_q <= in_cls_ok;
		end
	end

	// count lookup and stack address
	assign cnt = count_q[cls_q];
	always_comb begin
		if (cmd_q == sfl_pkg::CMD_RELEASE) begin
			slot = PW'(cnt - NW'(1));
		end else begin
			slot = PW'(cnt);
		end
		mem_addr = AW'(cls_q) * AW'(STACK_DEPTH) + AW'(slot);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sfl_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_d = sfl_pkg::ST_EXEC;
				end
			end
			sfl_pkg::ST_EXEC: begin
				if (out_free) begin
					if (cmd_q == sfl_pkg::CMD_RELEASE && cls_ok_q && cnt != '0) begin
						state_d = sfl_pkg::ST_READ;
					end else begin
						state_d = sfl_pkg::ST_IDLE;
					end
				end
			end
			sfl_pkg::ST_READ: begin
				if (out_free) begin
					state_d = sfl_pkg::ST_IDLE;
				end
			end
			default: state_d = sfl_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		cnt_we     = 1'b0;
		cnt_next   = cnt;
		res_load   = 1'b0;
		res_found  = 1'b0;
		res_addr   = '0;
		res_status = sfl_pkg::STATUS_OK;
		case (state_q)
			sfl_pkg::ST_EXEC: begin
				if (out_free) begin
					case (cmd_q)
						sfl_pkg::CMD_ADD: begin
							res_load = 1'b1;
							if (cnt == NW'(STACK_DEPTH)) begin
								res_status = sfl_pkg::STATUS_FULL;
							end else begin
								mem_we   = 1'b1;
								cnt_we   = 1'b1;
								cnt_next = cnt + NW'(1);
							end
						end
						sfl_pkg::CMD_SEARCH: begin
							res_load  = 1'b1;
							res_found = (cnt != '0);
						end
						sfl_pkg::CMD_RELEASE: begin
							if (cls_ok_q && cnt != '0) begin
								mem_re   = 1'b1;
								cnt_we   = 1'b1;
								cnt_next = cnt - NW'(1);
							end else begin
								res_load   = 1'b1;
								res_status = sfl_pkg::STATUS_EMPTY;
							end
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			sfl_pkg::ST_READ: begin
				if (out_free) begin
					res_load = 1'b1;
					res_addr = rd_data_q;
				end
			end
			default: begin
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// per-class counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				count_q[i] <= '0;
			end
		end else if (cnt_we) begin
			count_q[cls_q] <= cnt_next;
		end
	end

	// stack memory, one port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_addr] <= addr_q;
		end
		if (mem_re) begin
			rd_data_q <= stack_mem[mem_addr];
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			found_q    <= res_found;
			addr_out_q <= res_addr;
			status_q   <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign addr_out  = addr_out_q;
	assign status    = status_q;

endmodule

`default_nettype wire

// ----- tb/tb_segregated_free_list.sv -----
// self-checking testbench for the segregated free list allocator
`timescale 1ns / 1ps

module tb_segregated_free_list;
	import sfl_pkg::*;

	localparam int NCLS = NUM_CLASSES_DEF;
	localparam int DEPTH = STACK_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1200;
	localparam int HOLD_CYCLES = 200;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 20;
	localparam int REPORT_MAX = 10;
	// command code with no meaning to the block
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [ADDR_W-1:0] blk_addr;
		logic [SIZE_W-1:0] blk_size;
		logic [IDX_W-1:0]  cls_idx;
	} alloc_cmd_t;

	typedef struct packed {
		logic                found;
		logic [ADDR_W-1:0]   addr;
		logic [STATUS_W-1:0] status;
	} alloc_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CMD_W-1:0] command = CMD_ADD;
	logic [ADDR_W-1:0] block_addr = '0;
	logic [SIZE_W-1:0] block_size = '0;
	logic [IDX_W-1:0] class_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic found;
	logic [ADDR_W-1:0] addr_out;
	logic [STATUS_W-1:0] status;

	// predicted allocator state
	logic [ADDR_W-1:0] free_stack [NCLS][DEPTH];
	int unsigned free_count [NCLS];

	alloc_cmd_t pending_cmds [$];
	alloc_result_t expected_results [$];
	alloc_cmd_t offered;
	int unsigned cmds_accepted = 0;
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned hold_left = 0;
	logic pressure_done = 1'b0;

	segregated_free_list uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.block_addr(block_addr),
		.block_size(block_size),
		.class_index(class_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found(found),
		.addr_out(addr_out),
		.status(status)
	);

	always #6 clk = ~clk;

	// size class of a block, saturated to the table
	function automatic int class_of_size(input logic [SIZE_W-1:0] sz);
		int msb;
		int cls;
		msb = 0;
		for (int b = 0; b < SIZE_W; b++) begin
			if (sz[b]) msb = b;
		end
		cls = (msb <= CLASS_SHIFT) ? 0 : msb - CLASS_SHIFT;
		return (cls >= NCLS) ? NCLS - 1 : cls;
	endfunction

	// random size that lands in the given class, or in class 28 for classes above 28
	function automatic logic [SIZE_W-1:0] size_in_class(input int cls);
		int lg;
		logic [SIZE_W-1:0] low_mask;
		if (cls == 0) return SIZE_W'($urandom_range(15));
		lg = ((cls > 28) ? 28 : cls) + CLASS_SHIFT;
		low_mask = (32'd1 << lg) - 32'd1;
		return (32'd1 << lg) | ($urandom & low_mask);
	endfunction

	// apply one command to the predicted stacks and return its result
	function automatic alloc_result_t apply_command(input alloc_cmd_t c);
		alloc_result_t r;
		int cls;
		int unsigned n;
		r = '0;
		case (c.command)
			CMD_ADD: begin
				cls = class_of_size(c.blk_size);
				n = free_count[cls];
				if (n >= DEPTH) begin
					r.status = STATUS_FULL;
				end else begin
					free_stack[cls][n] = c.blk_addr;
					free_count[cls] = n + 1;
				end
			end
			CMD_SEARCH: begin
				r.found = (free_count[class_of_size(c.blk_size)] != 0);
			end
			CMD_RELEASE: begin
				if (int'(c.cls_idx) < NCLS && free_count[c.cls_idx] != 0) begin
					n = free_count[c.cls_idx] - 1;
					r.addr = free_stack[c.cls_idx][n];
					free_count[c.cls_idx] = n;
				end else begin
					r.status = STATUS_EMPTY;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] a,
			input logic [SIZE_W-1:0] sz, input logic [IDX_W-1:0] idx);
		alloc_cmd_t c;
		c.command = cmd;
		c.blk_addr = a;
		c.blk_size = sz;
		c.cls_idx = idx;
		pending_cmds.push_back(c);
	endtask

	task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] exp_val,
			input logic [ADDR_W-1:0] act_val);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("%0t: %s mismatch, expected %h, got %h", $realtime, what, exp_val, act_val);
	endtask

	function automatic int send_idle_pct();
		if (cmds_accepted < 400) return 17;
		if (cmds_accepted < 800) return 88;
		return 0;
	endfunction

	function automatic int recv_idle_pct();
		if (cmds_accepted < 400) return 88;
		if (cmds_accepted < 800) return 17;
		return 0;
	endfunction

	// command driver: predicts on each input transfer, then offers the next command
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(apply_command(offered));
				cmds_accepted <= cmds_accepted + 1;
			end
			if (!in_valid || !in_stall) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
					offered = pending_cmds.pop_front();
					in_valid <= 1'b1;
					command <= offered.command;
					block_addr <= offered.blk_addr;
					block_size <= offered.blk_size;
					class_index <= offered.cls_idx;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver stall, with one long hold-off to back up the input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			pressure_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (!pressure_done && cmds_accepted >= 900) begin
			hold_left <= HOLD_CYCLES;
			pressure_done <= 1'b1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct());
		end
	end

	// result monitor: compare each output transfer with the oldest prediction
	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, addr_out", '0, addr_out);
			end else begin
				want = expected_results.pop_front();
				if (found !== want.found)
					report_mismatch("found", ADDR_W'(want.found), ADDR_W'(found));
				if (addr_out !== want.addr) report_mismatch("addr_out", want.addr, addr_out);
				if (status !== want.status)
					report_mismatch("status", ADDR_W'(want.status), ADDR_W'(status));
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_segregated_free_list: done, errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int hot [3];
		int target;
		int roll;
		int add_pct;
		int rel_pct;
		logic [CMD_W-1:0] op;
		logic [SIZE_W-1:0] sz;

		// directed: empty release, extreme sizes, release from high classes, unused code
		queue_cmd(CMD_RELEASE, '0, '0, '0);
		queue_cmd(CMD_SEARCH, '0, '0, '0);
		queue_cmd(CMD_ADD, '1, '1, '0);
		queue_cmd(CMD_SEARCH, '0, '1, '0);
		queue_cmd(CMD_RELEASE, '0, '0, 5'd28);
		queue_cmd(CMD_RELEASE, '0, '0, 5'd31);
		queue_cmd(CMD_UNUSED, '1, '1, '1);
		// fill class 0 past its depth so the last add reports full
		for (int k = 0; k <= DEPTH; k++)
			queue_cmd(CMD_ADD, 32'(k) * 32'h0F0F_0F0F, SIZE_W'(k % 16), '0);
		queue_cmd(CMD_SEARCH, '0, 32'd8, '0);
		queue_cmd(CMD_RELEASE, '0, '0, '0);

		// random: a few hot classes, alternating fill-heavy and drain-heavy stretches
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 150 == 0) begin
				for (int h = 0; h < 3; h++) hot[h] = $urandom_range(28);
			end
			add_pct = ((i / 100) % 2 == 0) ? 60 : 20;
			rel_pct = ((i / 100) % 2 == 0) ? 20 : 60;
			target = ($urandom_range(99) < 75) ? hot[$urandom_range(2)] : $urandom_range(31);
			roll = $urandom_range(99);
			if (roll < add_pct) op = CMD_ADD;
			else if (roll < add_pct + 15) op = CMD_SEARCH;
			else if (roll < add_pct + 15 + rel_pct) op = CMD_RELEASE;
			else op = CMD_UNUSED;
			sz = ($urandom_range(99) < 10) ? $urandom : size_in_class(target);
			queue_cmd(op, $urandom, sz,
				(op == CMD_RELEASE) ? IDX_W'(target) : IDX_W'($urandom_range(31)));
		end

		for (int c = 0; c < NCLS; c++) free_count[c] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// drain: all commands in, all results out, then a short settle
		while (pending_cmds.size() != 0 || in_valid) @(negedge clk);
		while (expected_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("tb_segregated_free_list: done, clean");
		end else begin
			$display("tb_segregated_free_list: done, errors");
		end
		$finish;
	end

endmodule
